>>> design/nmea_gga_sentence_framer_top_defines.svh
// ---------------------------------------------------------------------------
// NMEA GGA sentence framer assertion macros
// Shared concurrent assertion forms for the framer's checker.
// ---------------------------------------------------------------------------
`ifndef NMEA_GGA_SENTENCE_FRAMER_TOP_DEFINES_SVH
`define NMEA_GGA_SENTENCE_FRAMER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define NGSF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define NGSF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/ngsf_pkg.sv
// ---------------------------------------------------------------------------
// NMEA GGA sentence framer package
// Characters, sizes, phase codes and item types shared by the framer.
// ---------------------------------------------------------------------------
package ngsf_pkg;

   // Sentence buffer length and the last index a body byte may take
   localparam int BufferLen = 128;
   localparam logic [7:0] BodyLast  = 8'(BufferLen - 1);
   localparam logic [7:0] BodyFirst = 8'd6;

   // Header byte positions ('$' is position 0)
   localparam logic [2:0] HdrFirst  = 3'd1;
   localparam logic [2:0] HdrLetter0 = 3'd3;
   localparam logic [2:0] HdrLetter1 = 3'd4;
   localparam logic [2:0] HdrLast   = 3'd5;

   // Framing characters
   localparam logic [7:0] ChStart = 8'h24;
   localparam logic [7:0] ChStar  = 8'h2A;
   localparam logic [7:0] ChCr    = 8'h0D;
   localparam logic [7:0] ChLf    = 8'h0A;

   // Sentence type after reset: "GGA"
   localparam logic [23:0] TypeReset = 24'h474741;

   // Reported phase codes
   localparam logic [1:0] PhaseCodeWait   = 2'd0;
   localparam logic [1:0] PhaseCodeHeader = 2'd1;
   localparam logic [1:0] PhaseCodeBody   = 2'd2;
   localparam logic [1:0] PhaseCodeCsum   = 2'd3;

   typedef enum logic [3:0] {
      PhWait   = 4'b0001,
      PhHeader = 4'b0010,
      PhBody   = 4'b0100,
      PhCsum   = 4'b1000
   } phase_type;

   // Held input item
   typedef struct packed {
      logic       valid;
      logic [7:0] rx_byte;
   } item_type;

   // One result item
   typedef struct packed {
      logic [1:0] parser_phase;
      logic       sentence_dropped;
      logic       sentence_done;
      logic [7:0] write_byte;
      logic [6:0] write_index;
      logic       buffer_write;
   } result_type;

endpackage

>>> design/nmea_gga_sentence_framer_top.sv
// ---------------------------------------------------------------------------
// NMEA GGA sentence framer
// Frames one configured NMEA sentence type from a received byte stream.
// ---------------------------------------------------------------------------
//  channel | direction | payload
//  req_    | in        | tdata: rx_byte
//  rsp_    | out       | tdata: write flag, index, byte, dropped, phase; tlast: done
//  csr_    | in        | wdata: sentence_type, three letters
//
// One result item per received byte. A byte is held in the input register and
// its result in the result register; one byte per cycle while rsp is not stalled.
// A stalled rsp side holds the result register; the input register still
// takes one more byte. Reset (synchronous) empties both registers, returns
// the parser to waiting and restores the sentence type "GGA".
module nmea_gga_sentence_framer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [0] buffer_write, [7:1] write_index,
                                    // [15:8] write_byte, [16] sentence_dropped,
                                    // [18:17] parser_phase, [23:19] zero
   output logic        rsp_tlast,   // sentence_done
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [23:0] csr_wdata
);

   ngsf_pkg::item_type   item;
   ngsf_pkg::result_type result;
   logic                 advance;

   ngsf_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .item       (item)
   );

   ngsf_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .item      (item),
      .advance   (advance),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata),
      .result    (result)
   );

   ngsf_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item.valid),
      .result     (result),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> design/ngsf_in_stage.sv
// ---------------------------------------------------------------------------
// NMEA framer input stage
// Registers one received byte and holds it until the parser takes it.
// ---------------------------------------------------------------------------
module ngsf_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,
   input  logic               advance,
   output ngsf_pkg::item_type item
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       accept;

   // Take a new item when empty or when the held one moves on
   assign req_tready = !valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the byte
   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_tdata;
      end
   end

   assign item.valid   = valid_ff;
   assign item.rx_byte = byte_ff;

endmodule

>>> design/ngsf_parser.sv
// ---------------------------------------------------------------------------
// NMEA framer parser
// Sentence phase state, header check and buffer write generation per byte.
// ---------------------------------------------------------------------------
module ngsf_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  ngsf_pkg::item_type   item,
   input  logic                 advance,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [23:0]          csr_wdata,
   output ngsf_pkg::result_type result
);

   ngsf_pkg::phase_type phase_ff, phase_in;
   logic [2:0]  hdr_count_ff, hdr_count_in;
   logic [7:0]  letter0_ff, letter1_ff;
   logic [7:0]  body_index_ff, body_index_in;
   logic [23:0] type_ff;
   logic [7:0]  b;
   logic        line_end;
   logic        at_end;

   assign csr_ready = 1'b1;
   assign b         = item.rx_byte;
   assign line_end  = (b == ngsf_pkg::ChCr) || (b == ngsf_pkg::ChLf);
   assign at_end    = body_index_ff >= ngsf_pkg::BodyLast;

   // Work out next state and the result for the held byte
   always_comb begin
      phase_in      = phase_ff;
      hdr_count_in  = hdr_count_ff;
      body_index_in = body_index_ff;
      result        = '0;
      case (phase_ff)
         ngsf_pkg::PhWait: begin
            if (b == ngsf_pkg::ChStart) begin
               hdr_count_in = ngsf_pkg::HdrFirst;
               phase_in     = ngsf_pkg::PhHeader;
            end
         end
         ngsf_pkg::PhHeader: begin
            hdr_count_in = hdr_count_ff + 3'd1;
            if (hdr_count_ff == ngsf_pkg::HdrLast) begin
               if ({letter0_ff, letter1_ff, b} == type_ff) begin
                  body_index_in = ngsf_pkg::BodyFirst;
                  phase_in      = ngsf_pkg::PhBody;
               end else begin
                  phase_in = ngsf_pkg::PhWait;
               end
            end
         end
         ngsf_pkg::PhBody: begin
            result.buffer_write = 1'b1;
            result.write_index  = body_index_ff[6:0];
            result.write_byte   = b;
            body_index_in       = body_index_ff + 8'd1;
            // Overflow wins over '*'
            if (line_end || at_end) begin
               phase_in                = ngsf_pkg::PhWait;
               result.sentence_dropped = 1'b1;
            end else if (b == ngsf_pkg::ChStar) begin
               phase_in = ngsf_pkg::PhCsum;
            end
         end
         ngsf_pkg::PhCsum: begin
            result.buffer_write = 1'b1;
            result.write_index  = body_index_ff[6:0];
            result.write_byte   = b;
            body_index_in       = body_index_ff + 8'd1;
            if (line_end) begin
               phase_in             = ngsf_pkg::PhWait;
               result.sentence_done = 1'b1;
            end else if (at_end) begin
               phase_in                = ngsf_pkg::PhWait;
               result.sentence_dropped = 1'b1;
            end
         end
         default: begin
            phase_in = ngsf_pkg::PhWait;
         end
      endcase

      // Report the phase after this byte
      case (phase_in)
         ngsf_pkg::PhWait:   result.parser_phase = ngsf_pkg::PhaseCodeWait;
         ngsf_pkg::PhHeader: result.parser_phase = ngsf_pkg::PhaseCodeHeader;
         ngsf_pkg::PhBody:   result.parser_phase = ngsf_pkg::PhaseCodeBody;
         ngsf_pkg::PhCsum:   result.parser_phase = ngsf_pkg::PhaseCodeCsum;
         default:            result.parser_phase = ngsf_pkg::PhaseCodeWait;
      endcase
   end

   // Advance control state once per byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= ngsf_pkg::PhWait;
         hdr_count_ff  <= '0;
         body_index_ff <= '0;
      end else if (advance) begin
         phase_ff      <= phase_in;
         hdr_count_ff  <= hdr_count_in;
         body_index_ff <= body_index_in;
      end
   end

   // Capture the first two type letters of the header
   always_ff @(posedge clock) begin
      if (advance && (phase_ff == ngsf_pkg::PhHeader)) begin
         if (hdr_count_ff == ngsf_pkg::HdrLetter0) begin
            letter0_ff <= b;
         end
         if (hdr_count_ff == ngsf_pkg::HdrLetter1) begin
            letter1_ff <= b;
         end
      end
   end

   // Sentence type register
   always_ff @(posedge clock) begin
      if (reset) begin
         type_ff <= ngsf_pkg::TypeReset;
      end else if (csr_valid && csr_ready) begin
         type_ff <= csr_wdata;
      end
   end

endmodule

>>> design/ngsf_out_stage.sv
// ---------------------------------------------------------------------------
// NMEA framer output stage
// Result register toward the response channel, and the advance decision.
// ---------------------------------------------------------------------------
module ngsf_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  ngsf_pkg::result_type result,
   output logic                 advance,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [23:0]          rsp_tdata,
   output logic                 rsp_tlast
);

   logic                 valid_ff;
   logic                 valid_in;
   ngsf_pkg::result_type data_ff;

   // Move the held item when the result register is free or draining
   assign advance = item_valid && (!valid_ff || rsp_tready);

   always_comb begin
      if (advance) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = data_ff.sentence_done;
   assign rsp_tdata  = {5'd0,
                        data_ff.parser_phase,
                        data_ff.sentence_dropped,
                        data_ff.write_byte,
                        data_ff.write_index,
                        data_ff.buffer_write};

endmodule

>>> design/ngsf_checker.sv
// ---------------------------------------------------------------------------
// NMEA framer port checker
// Watches the response channel for framing consistency over time.
// ---------------------------------------------------------------------------
`include "nmea_gga_sentence_framer_top_defines.svh"

module ngsf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast
);

   // Stalled result stays offered
   `NGSF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid,
                     "rsp item withdrawn while stalled")

   // Done ends a sentence: written byte, back to waiting, not dropped
   `NGSF_ASSERT_NOW(a_done_ends, clock, reset, rsp_tvalid && rsp_tlast,
                    rsp_tdata[0] && (rsp_tdata[18:17] == ngsf_pkg::PhaseCodeWait)
                    && !rsp_tdata[16],
                    "done without write or not waiting")

   // Drop returns to waiting after a written byte
   `NGSF_ASSERT_NOW(a_drop_ends, clock, reset, rsp_tvalid && rsp_tdata[16],
                    rsp_tdata[0] && (rsp_tdata[18:17] == ngsf_pkg::PhaseCodeWait),
                    "drop without write or not waiting")

   // No write means zero index and byte, and no done
   `NGSF_ASSERT_NOW(a_idle_zero, clock, reset, rsp_tvalid && !rsp_tdata[0],
                    (rsp_tdata[15:1] == 15'd0) && !rsp_tlast,
                    "payload set without buffer write")

endmodule

bind nmea_gga_sentence_framer_top ngsf_checker u_ngsf_checker (.*);

>>> tb/nmea_gga_sentence_framer_top_tb.sv
// ---------------------------------------------------------------------------
// NMEA GGA sentence framer testbench
// Streams framed and broken NMEA sentences into the framer under several
// sentence types. Each accepted byte is run through a cycle-free copy of the
// framing rules, and every result item is checked against the oldest
// predicted result.
// ---------------------------------------------------------------------------
module nmea_gga_sentence_framer_top_tb;
   import ngsf_pkg::*;

   // Header is '$' plus five bytes
   localparam logic [2:0] HeaderLen = 3'd6;
   localparam int HoldOffCycles = 80;
   localparam int PhaseItems = 215;
   localparam int NumPhases = 6;

   // Tracks the framer state and queues the predicted result of every byte
   class frame_tracker;
      logic [1:0]  phase_code;
      logic [2:0]  hdr_count;
      logic [7:0]  letters [3];
      logic [7:0]  body_index;
      logic [23:0] sentence_type;
      result_type  predicted[$];
      int          failures;

      function new();
         phase_code    = PhaseCodeWait;
         hdr_count     = '0;
         letters[0]    = '0;
         letters[1]    = '0;
         letters[2]    = '0;
         body_index    = '0;
         sentence_type = TypeReset;
         failures      = 0;
      endfunction

      function void set_type(logic [23:0] t);
         sentence_type = t;
      endfunction

      function int pending();
         return predicted.size();
      endfunction

      // Advance the framing state by one byte and queue its result
      function void note_byte(logic [7:0] b);
         result_type r;
         logic       line_end;
         logic       at_end;
         r        = '0;
         line_end = (b == ChCr) || (b == ChLf);
         case (phase_code)
            PhaseCodeWait: begin
               if (b == ChStart) begin
                  hdr_count  = 3'd1;
                  phase_code = PhaseCodeHeader;
               end
            end
            PhaseCodeHeader: begin
               if (hdr_count >= HdrLetter0 && hdr_count <= HdrLast)
                  letters[hdr_count - HdrLetter0] = b;
               hdr_count = hdr_count + 3'd1;
               if (hdr_count >= HeaderLen) begin
                  if ({letters[0], letters[1], letters[2]} == sentence_type) begin
                     body_index = BodyFirst;
                     phase_code = PhaseCodeBody;
                  end else begin
                     phase_code = PhaseCodeWait;
                  end
               end
            end
            PhaseCodeBody: begin
               r.buffer_write = 1'b1;
               r.write_index  = body_index[6:0];
               r.write_byte   = b;
               at_end         = body_index >= BodyLast;
               // overflow wins over '*'
               if (line_end || at_end) begin
                  phase_code         = PhaseCodeWait;
                  r.sentence_dropped = 1'b1;
               end else if (b == ChStar) begin
                  phase_code = PhaseCodeCsum;
               end
               body_index = body_index + 8'd1;
            end
            default: begin
               r.buffer_write = 1'b1;
               r.write_index  = body_index[6:0];
               r.write_byte   = b;
               at_end         = body_index >= BodyLast;
               if (line_end) begin
                  r.sentence_done = 1'b1;
                  phase_code      = PhaseCodeWait;
               end else if (at_end) begin
                  r.sentence_dropped = 1'b1;
                  phase_code         = PhaseCodeWait;
               end
               body_index = body_index + 8'd1;
            end
         endcase
         r.parser_phase = phase_code;
         predicted.push_back(r);
      endfunction

      // Compare one result item with the oldest prediction
      function void check_result(logic [23:0] data, logic done);
         result_type exp;
         result_type got;
         logic       bad;
         got.buffer_write     = data[0];
         got.write_index      = data[7:1];
         got.write_byte       = data[15:8];
         got.sentence_dropped = data[16];
         got.parser_phase     = data[18:17];
         got.sentence_done    = done;
         if (predicted.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected result: tdata=%h tlast=%b", data, done);
            return;
         end
         exp = predicted.pop_front();
         bad = (got.buffer_write != exp.buffer_write)
            || (got.write_index != exp.write_index)
            || (got.write_byte != exp.write_byte)
            || (got.sentence_done != exp.sentence_done)
            || (got.sentence_dropped != exp.sentence_dropped)
            || (got.parser_phase != exp.parser_phase)
            || (data[23:19] != 5'd0);
         if (bad) begin
            failures++;
            if (failures <= 10)
               $display({"mismatch: exp wr=%b idx=%0d byte=%h done=%b drop=%b ph=%0d",
                         " | got wr=%b idx=%0d byte=%h done=%b drop=%b ph=%0d pad=%h"},
                        exp.buffer_write, exp.write_index, exp.write_byte,
                        exp.sentence_done, exp.sentence_dropped, exp.parser_phase,
                        got.buffer_write, got.write_index, got.write_byte,
                        got.sentence_done, got.sentence_dropped, got.parser_phase,
                        data[23:19]);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [23:0] csr_wdata  = '0;

   frame_tracker tracker = new();

   int          req_gap_max     = 16;
   int          rsp_gap_max     = 16;
   int          rsp_hold_cycles = 0;
   int          bytes_sent      = 0;
   logic [23:0] cur_type        = TypeReset;

   nmea_gga_sentence_framer_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Give up on a hung run
   initial begin
      #1000000;
      $display("nmea_gga_sentence_framer_top_tb NOT OK");
      $finish;
   end

   // Check every accepted result item
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_result(rsp_tdata, rsp_tlast);
   end

   // Drive rsp_tready: random stall per item, or one long hold-off on request
   initial begin : rsp_driver
      int stall;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            stall           = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = $urandom_range(0, rsp_gap_max);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // Offer one byte; entered and left at a falling edge with valid still high
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      tracker.note_byte(b);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i]);
   endtask

   // Hold the sender until every predicted result has come out
   task automatic drain();
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_type(input logic [23:0] t);
      csr_valid <= 1'b1;
      csr_wdata <= t;
      do @(posedge clock); while (!csr_ready);
      tracker.set_type(t);
      cur_type = t;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] line_end_char();
      return ($urandom_range(0, 1) == 0) ? ChCr : ChLf;
   endfunction

   // Random byte that does not end or split the body
   function automatic logic [7:0] plain_char();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if (b == ChCr || b == ChLf || b == ChStar)
         b = ",";
      return b;
   endfunction

   // One random sentence: mostly well formed, some broken, some line noise
   task automatic send_sentence();
      int          kind;
      int          n;
      int          flip;
      logic [23:0] letters;
      kind = $urandom_range(0, 99);
      if (kind >= 80) begin
         n = $urandom_range(1, 8);
         repeat (n) send_byte(8'($urandom_range(0, 255)));
         return;
      end
      letters = cur_type;
      // spoil one letter bit for a header mismatch
      if (kind >= 55 && kind < 70) begin
         flip          = $urandom_range(0, 23);
         letters[flip] = ~letters[flip];
      end
      send_byte(ChStart);
      send_byte(8'($urandom_range(0, 255)));
      send_byte(8'($urandom_range(0, 255)));
      send_byte(letters[23:16]);
      send_byte(letters[15:8]);
      send_byte(letters[7:0]);
      n = ($urandom_range(0, 11) == 0) ? $urandom_range(100, 130) : $urandom_range(0, 20);
      repeat (n) send_byte(plain_char());
      if (kind >= 70) begin
         send_byte(line_end_char());
         return;
      end
      send_byte(ChStar);
      n = ($urandom_range(0, 11) == 0) ? $urandom_range(100, 125) : 2;
      repeat (n) begin
         send_byte(8'($urandom_range(0, 255)));
         // stop once an overflow has closed the sentence
         if (tracker.phase_code == PhaseCodeWait)
            return;
      end
      send_byte(line_end_char());
   endtask

   initial begin : stimulus
      int          stop;
      logic [23:0] next_type;
      logic        held;
      logic        paused;
      held   = 1'b0;
      paused = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: full sentence with byte extremes and '$' in the body
      send_text("$GPGGA,$");
      send_byte(8'hFF);
      send_byte(8'h00);
      send_text("*4");
      send_byte(ChCr);
      // header mismatch, then a line end inside the body
      send_text("$GPRMC");
      send_text("$GNGGA");
      send_byte(ChLf);

      for (int p = 0; p < NumPhases; p++) begin
         if (p > 0) begin
            drain();
            case (p)
               1:       next_type = 24'h524D43;
               2:       next_type = 24'h000000;
               3:       next_type = 24'hFFFFFF;
               4:       next_type = 24'($urandom);
               default: next_type = TypeReset;
            endcase
            write_type(next_type);
         end
         // alternate busy phases with phases that never idle
         case (p)
            1:       begin req_gap_max = 0;  rsp_gap_max = 0;  end
            2:       begin req_gap_max = 16; rsp_gap_max = 0;  end
            3:       begin req_gap_max = 0;  rsp_gap_max = 16; end
            default: begin req_gap_max = 16; rsp_gap_max = 16; end
         endcase
         stop = bytes_sent + PhaseItems;
         while (bytes_sent < stop) begin
            if (p == 1 && !held && bytes_sent > stop - 150) begin
               rsp_hold_cycles = HoldOffCycles;
               held            = 1'b1;
            end
            if (p == 2 && !paused && bytes_sent > stop - 100) begin
               drain();
               paused = 1'b1;
            end
            send_sentence();
         end
      end

      drain();
      repeat (8) @(negedge clock);
      if (tracker.failures == 0 && tracker.pending() == 0)
         $display("nmea_gga_sentence_framer_top_tb OK");
      else
         $display("nmea_gga_sentence_framer_top_tb NOT OK");
      $finish;
   end

endmodule
